[hw/rtl/ssc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and codes of the snapshot stream checker.
// ----------------------------------------------------------------------------
package ssc_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [31:0] MAGIC_DEFAULT   = 32'h504C_4601;
   localparam logic [31:0] VERSION_DEFAULT = 32'd1;

   localparam logic CSR_MAGIC   = 1'b0;
   localparam logic CSR_VERSION = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_MAGIC     = 3'd2,
      ST_VERSION   = 3'd3,
      ST_GEOMETRY  = 3'd4,
      ST_INTEGRITY = 3'd5,
      ST_CHECKSUM  = 3'd6
   } status_type;

   typedef enum logic {
      KIND_CORE   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    record_kind;
      logic [5:0]  lane_index;
      logic [2:0]  slot_index;
      logic [63:0] core_value;
      status_type  status_code;
      logic [31:0] written_total;
      logic [31:0] collision_total;
      logic        run_end;
   } record_type;

   typedef struct packed {
      logic push0;
      logic push1;
   } push_type;

endpackage

[hw/rtl/ssc_result_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_result_fifo
// Small result queue; takes up to two records per cycle, hands out one.
// ----------------------------------------------------------------------------
module ssc_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  ssc_pkg::push_type   push,
   input  ssc_pkg::record_type push_data0,
   input  ssc_pkg::record_type push_data1,
   output logic                space_ok,
   output logic                head_valid,
   input  logic                head_ready,
   output ssc_pkg::record_type head_data
);

   localparam int unsigned DEPTH = ssc_pkg::QUEUE_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   ssc_pkg::record_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [CNT_W-1:0] push_cnt;
   logic             pop;

   assign pop         = head_valid && head_ready;
   assign push_cnt    = CNT_W'(push.push0) + CNT_W'(push.push1);
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in   = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in    = count_ff + push_cnt - CNT_W'(pop);

   assign space_ok   = count_ff <= CNT_W'(DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[wr_ptr_ff] <= push_data0;
      end
      if (push.push1) begin
         entry_ff[wr_ptr_next] <= push_data1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overfilled");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != '0) |-> (count_ff <= CNT_W'(DEPTH - 2)))
      else $error("push without room");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push_cnt == '0) |=> (count_ff == '0))
      else $error("empty queue became non-empty without a push");

endmodule

[hw/rtl/snapshot_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snapshot_stream_checker
// Byte-serial checker and core extractor for a fixed-layout snapshot.
//
// Usage: bytes enter on req_* one per transaction, req_tlast marking the
// final byte of a buffer. Each stored core whose slot is below its lane's
// count byte leaves on rsp_* as a core record (rsp_tuser = 0), unless a header
// check failed. After the last snapshot byte (or an early req_tlast) one
// status record (rsp_tuser = 1) carries the verdict and the footer
// totals. rsp_tlast marks the last record caused by one input byte. After a
// status, bytes are dropped until a byte with req_tlast, then a new run starts.
// Throughput: one byte per cycle while req_tready is high. Each record
// queues behind older ones on its way to rsp_*. The per-byte work is a
// counter step, a byte shift and a 32-bit XOR between the state registers
// and a four-entry result queue; the queue stalls req_tready only when
// fewer than two entries are free, which happens only after rsp_tready was low.
// Reset clears all run state and loads the csr_* registers with defaults.
// The user makes csr_* writes only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module snapshot_stream_checker #(
   parameter int unsigned NUM_LANES      = 54,
   parameter int unsigned SLOTS_PER_LANE = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // [5:0] lane_index, [8:6] slot_index,
                                     // [72:9] core_value, [75:73] status_code,
                                     // [107:76] written_total,
                                     // [139:108] collision_total, rest zero
   output logic         rsp_tuser,   // [0] record_kind
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [31:0]  csr_wr_data
);

   localparam int unsigned HEADER_BYTES = 24;
   localparam int unsigned LANE_BYTES   = 16 + 8 * SLOTS_PER_LANE;
   localparam int unsigned CORE_END     = 8 + 8 * SLOTS_PER_LANE;
   localparam int unsigned FOOTER_AT    = HEADER_BYTES + NUM_LANES * LANE_BYTES;
   localparam int unsigned SNAP_BYTES   = FOOTER_AT + 12;
   localparam int unsigned POS_W        = $clog2(SNAP_BYTES);
   localparam int unsigned OFF_W        = $clog2(LANE_BYTES);
   localparam int unsigned LANE_W       = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
   localparam int unsigned CMP_W        = (OFF_W > 8) ? OFF_W : 8;

   logic [31:0]       magic_ff, magic_in;
   logic [31:0]       version_ff, version_in;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic [63:0]       asm_ff, asm_in;
   logic [31:0]       fold_ff, fold_in;
   logic [63:0]       lsum_ff, lsum_in;
   logic [63:0]       gsum_ff, gsum_in;
   logic [7:0]        count_ff, count_in;
   ssc_pkg::status_type hdr_err_ff, hdr_err_in;
   logic [31:0]       fwritten_ff, fwritten_in;
   logic [31:0]       fcoll_ff, fcoll_in;
   logic              finished_ff, finished_in;

   logic              accept;
   logic [63:0]       asm_new;
   logic [31:0]       word;
   logic [OFF_W-1:0]  slot_full;
   logic              in_lanes;
   logic              core_hit;
   logic              status_hit;
   ssc_pkg::record_type core_rec, status_rec, rec0, rec1;
   ssc_pkg::push_type push;
   ssc_pkg::record_type head;

   assign accept    = req_tvalid && req_tready;
   assign asm_new   = {req_tdata, asm_ff[63:8]};
   assign word      = asm_new[63:32];
   assign slot_full = (off_ff >> 3) - OFF_W'(1);
   assign in_lanes  = pos_ff >= POS_W'(HEADER_BYTES) && pos_ff < POS_W'(FOOTER_AT);

   // csr writes
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ssc_pkg::CSR_MAGIC:   magic_in   = csr_wr_data;
            ssc_pkg::CSR_VERSION: version_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // per-byte parse
   always_comb begin
      pos_in      = pos_ff;
      off_in      = off_ff;
      lane_in     = lane_ff;
      asm_in      = asm_ff;
      fold_in     = fold_ff;
      lsum_in     = lsum_ff;
      gsum_in     = gsum_ff;
      count_in    = count_ff;
      hdr_err_in  = hdr_err_ff;
      fwritten_in = fwritten_ff;
      fcoll_in    = fcoll_ff;
      finished_in = finished_ff;
      core_hit    = 1'b0;
      status_hit  = 1'b0;
      core_rec    = '0;
      status_rec  = '0;

      core_rec.record_kind = ssc_pkg::KIND_CORE;
      core_rec.lane_index  = 6'(lane_ff);
      core_rec.slot_index  = 3'(slot_full);
      core_rec.core_value  = asm_new;
      core_rec.status_code = ssc_pkg::ST_OK;
      status_rec.record_kind = ssc_pkg::KIND_STATUS;
      status_rec.run_end     = 1'b1;

      if (accept && finished_ff) begin
         if (req_tlast) begin
            finished_in = 1'b0;
         end
      end else if (accept) begin
         asm_in = asm_new;
         if (pos_ff[1:0] == 2'd3 && pos_ff < POS_W'(SNAP_BYTES - 4)) begin
            fold_in = fold_ff ^ word;
         end

         if (pos_ff < POS_W'(HEADER_BYTES)) begin
            if (hdr_err_ff == ssc_pkg::ST_OK) begin
               if (pos_ff == POS_W'(3) && word != magic_ff) begin
                  hdr_err_in = ssc_pkg::ST_MAGIC;
               end else if (pos_ff == POS_W'(7) && word != version_ff) begin
                  hdr_err_in = ssc_pkg::ST_VERSION;
               end else if (pos_ff == POS_W'(11) && word != 32'(NUM_LANES)) begin
                  hdr_err_in = ssc_pkg::ST_GEOMETRY;
               end else if (pos_ff == POS_W'(15) && word != 32'(SLOTS_PER_LANE)) begin
                  hdr_err_in = ssc_pkg::ST_GEOMETRY;
               end
            end
            if (pos_ff == POS_W'(23)) begin
               gsum_in = asm_new;
            end
         end else if (in_lanes) begin
            if (off_ff == '0) begin
               count_in = req_tdata;
            end else if (off_ff >= OFF_W'(8) && off_ff < OFF_W'(CORE_END)) begin
               if (off_ff[2:0] == 3'd7 && CMP_W'(slot_full) < CMP_W'(count_ff)
                   && hdr_err_ff == ssc_pkg::ST_OK) begin
                  core_hit = 1'b1;
               end
            end else if (off_ff == OFF_W'(LANE_BYTES - 1)) begin
               lsum_in = lsum_ff ^ asm_new;
            end
            if (off_ff == OFF_W'(LANE_BYTES - 1)) begin
               off_in  = '0;
               lane_in = lane_ff + LANE_W'(1);
            end else begin
               off_in = off_ff + OFF_W'(1);
            end
         end else begin
            if (pos_ff == POS_W'(FOOTER_AT + 3)) begin
               fwritten_in = word;
            end else if (pos_ff == POS_W'(FOOTER_AT + 7)) begin
               fcoll_in = word;
            end
         end

         if (pos_ff == POS_W'(SNAP_BYTES - 1) || req_tlast) begin
            status_hit = 1'b1;
            if (pos_ff == POS_W'(SNAP_BYTES - 1)) begin
               status_rec.written_total   = fwritten_ff;
               status_rec.collision_total = fcoll_ff;
               if (hdr_err_ff != ssc_pkg::ST_OK) begin
                  status_rec.status_code = hdr_err_ff;
               end else if (fold_ff != word) begin
                  status_rec.status_code = ssc_pkg::ST_INTEGRITY;
               end else if (lsum_ff != gsum_ff) begin
                  status_rec.status_code = ssc_pkg::ST_CHECKSUM;
               end else begin
                  status_rec.status_code = ssc_pkg::ST_OK;
               end
               finished_in = !req_tlast;
            end else begin
               status_rec.status_code = ssc_pkg::ST_SHORT;
            end
            pos_in      = '0;
            off_in      = '0;
            lane_in     = '0;
            asm_in      = '0;
            fold_in     = '0;
            lsum_in     = '0;
            gsum_in     = '0;
            count_in    = '0;
            hdr_err_in  = ssc_pkg::ST_OK;
            fwritten_in = '0;
            fcoll_in    = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end

      core_rec.run_end = !status_hit;
      push.push0 = core_hit || status_hit;
      push.push1 = core_hit && status_hit;
      rec0 = core_hit ? core_rec : status_rec;
      rec1 = status_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= ssc_pkg::MAGIC_DEFAULT;
         version_ff  <= ssc_pkg::VERSION_DEFAULT;
         pos_ff      <= '0;
         off_ff      <= '0;
         lane_ff     <= '0;
         asm_ff      <= '0;
         fold_ff     <= '0;
         lsum_ff     <= '0;
         gsum_ff     <= '0;
         count_ff    <= '0;
         hdr_err_ff  <= ssc_pkg::ST_OK;
         fwritten_ff <= '0;
         fcoll_ff    <= '0;
         finished_ff <= 1'b0;
      end else begin
         magic_ff    <= magic_in;
         version_ff  <= version_in;
         pos_ff      <= pos_in;
         off_ff      <= off_in;
         lane_ff     <= lane_in;
         asm_ff      <= asm_in;
         fold_ff     <= fold_in;
         lsum_ff     <= lsum_in;
         gsum_ff     <= gsum_in;
         count_ff    <= count_in;
         hdr_err_ff  <= hdr_err_in;
         fwritten_ff <= fwritten_in;
         fcoll_ff    <= fcoll_in;
         finished_ff <= finished_in;
      end
   end

   ssc_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (rec0),
      .push_data1 (rec1),
      .space_ok   (req_tready),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .head_data  (head)
   );

   assign rsp_tdata = {4'd0, head.collision_total, head.written_total, head.status_code,
                       head.core_value, head.slot_index, head.lane_index};
   assign rsp_tuser = head.record_kind;
   assign rsp_tlast = head.run_end;

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (push.push0 && rec0.record_kind == ssc_pkg::KIND_CORE
                      && rec1.record_kind == ssc_pkg::KIND_STATUS))
      else $error("second record is not a status after a core");

   a_status_restart: assert property (@(posedge clock) disable iff (reset)
      status_hit |=> (pos_ff == '0 && hdr_err_ff == ssc_pkg::ST_OK))
      else $error("run state not cleared after status");

   a_no_core_on_error: assert property (@(posedge clock) disable iff (reset)
      core_hit |-> (hdr_err_ff == ssc_pkg::ST_OK && !finished_ff))
      else $error("core record after header error or finish");

endmodule
